FILE: rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Payload types, initial value and round helpers shared by the engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        final_word;
	} sm3_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_of_digest;
	} sm3_out_t;

	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [255:0] SM3_IV = {
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
	endfunction

endpackage

FILE: rtl/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streams a message in 32-bit words and returns the 256-bit SM3 digest.
// ----------------------------------------------------------------------------
// Input beats carry one big-endian message word; final_word marks the last
// one, whose byte_count (0..4, above 4 counts as 4) gives its valid bytes
// from the top. Every sixteenth word starts a compression of 64 rounds,
// one round per cycle, through a single round unit and a sliding 16-word
// message schedule. While compressing the block holds ready low, so no new
// word is taken until the compression is folded into the chaining value.
// On the final beat the padding words and the 64-bit length are loaded
// one per cycle, running one or two compressions, and then eight digest
// beats leave on the output channel, word_index 0 to 7. A stalled receiver
// holds the digest beat in place; no new word is taken until the eighth
// beat is gone. The block then returns to the initial value for the next
// message. Reset loads the initial value and clears length and count; the
// time from the final word to the first digest beat depends on how many
// padding blocks are needed.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sm3_pkg::sm3_in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output sm3_pkg::sm3_out_t out_data
);
	import sm3_pkg::*;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_INIT = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_FOLD = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]   state_q;
	logic [31:0]  w_q [16];
	logic [255:0] cv_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [3:0]   fill_q;
	logic [63:0]  bits_q;
	logic [5:0]   round_q;
	logic [2:0]   oidx_q;
	logic         fin_q;
	// Padding progress: pad_first_q set until 0x80 word placed.
	logic         pad_first_q;
	logic         last_blk_q;

	// Word produced this cycle for the block buffer.
	logic         push;
	logic [31:0]  push_word;
	logic [3:0]   cnt;
	logic [31:0]  keep, pad;
	logic [63:0]  bits_new;

	always_comb begin
		cnt = (in_data.byte_count > 3'd4 || !in_data.final_word) ? 4'd4 :
			{1'b0, in_data.byte_count};
		case (cnt[2:0])
			3'd0:    begin keep = 32'h0;        pad = {PAD_BYTE, 24'h0}; end
			3'd1:    begin keep = 32'hff000000; pad = {8'h0, PAD_BYTE, 16'h0}; end
			3'd2:    begin keep = 32'hffff0000; pad = {16'h0, PAD_BYTE, 8'h0}; end
			3'd3:    begin keep = 32'hffffff00; pad = {24'h0, PAD_BYTE}; end
			default: begin keep = 32'hffffffff; pad = 32'h0; end
		endcase
		bits_new = bits_q + {57'd0, cnt, 3'd0};
	end

	// Next padding word given position in the block.
	logic [31:0] pad_word;
	logic        pad_room;
	always_comb begin
		pad_room = 1'b0;
		if (pad_first_q) begin
			pad_word = {PAD_BYTE, 24'h0};
		end else if (fill_q < 4'd14) begin
			pad_word = 32'h0;
		end else if (!last_blk_q) begin
			pad_word = 32'h0;
		end else if (fill_q == 4'd14) begin
			pad_word = bits_q[63:32];
		end else begin
			pad_word = bits_q[31:0];
		end
		// The length fits only when the pad byte landed below fourteen.
		if (pad_first_q) pad_room = (fill_q < 4'd14);
	end

	// Round unit.
	logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wj, wj4, wnew;
	logic        lo;
	always_comb begin
		lo  = (round_q < 6'd16);
		tj  = lo ? T_LOW : T_HIGH;
		wj  = w_q[0];
		wj4 = w_q[4];
		a12 = rol(a_q, 5'd12);
		ss1 = rol(a12 + e_q + rol(tj, round_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		ff  = lo ? (a_q ^ b_q ^ c_q) : ((a_q & b_q) | (a_q & c_q) | (b_q & c_q));
		gg  = lo ? (e_q ^ f_q ^ g_q) : ((e_q & f_q) | (~e_q & g_q));
		tt1 = ff + d_q + ss2 + (wj ^ wj4);
		tt2 = gg + h_q + ss1 + wj;
		wnew = p1(w_q[0] ^ w_q[7] ^ rol(w_q[13], 5'd15)) ^ rol(w_q[3], 5'd7) ^ w_q[10];
	end

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_OUT);
	always_comb begin
		out_data.digest_word    = cv_q[255 - 32*oidx_q -: 32];
		out_data.word_index     = oidx_q;
		out_data.last_of_digest = (oidx_q == 3'd7);
	end

	always_comb begin
		push = 1'b0;
		push_word = pad_word;
		if (state_q == ST_LOAD && in_valid) begin
			push = 1'b1;
			push_word = (in_data.data_word & keep) | pad;
		end else if (state_q == ST_PAD) begin
			push = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) w_q[fill_q] <= push_word;
		else if (state_q == ST_RND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cv_q <= SM3_IV;
			fill_q <= 4'd0;
			bits_q <= 64'd0;
			round_q <= 6'd0;
			oidx_q <= 3'd0;
			fin_q <= 1'b0;
			pad_first_q <= 1'b0;
			last_blk_q <= 1'b0;
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: if (in_valid) begin
					bits_q <= bits_new;
					fill_q <= fill_q + 4'd1;
					if (in_data.final_word) begin
						fin_q <= 1'b1;
						// A full final word still needs its 0x80 word.
						pad_first_q <= (cnt == 4'd4);
						last_blk_q <= (cnt != 4'd4) && (fill_q < 4'd14);
						state_q <= (fill_q == 4'd15) ? ST_INIT : ST_PAD;
					end else if (fill_q == 4'd15) begin
						state_q <= ST_INIT;
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 4'd1;
					if (pad_first_q) begin
						pad_first_q <= 1'b0;
						last_blk_q <= pad_room;
					end
					if (fill_q == 4'd15) state_q <= ST_INIT;
				end
				ST_INIT: begin
					{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= cv_q;
					round_q <= 6'd0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					d_q <= c_q; c_q <= rol(b_q, 5'd9); b_q <= a_q; a_q <= tt1;
					h_q <= g_q; g_q <= rol(f_q, 5'd19); f_q <= e_q; e_q <= p0(tt2);
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					cv_q <= cv_q ^ {a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q};
					if (!fin_q) state_q <= ST_LOAD;
					else if (last_blk_q) begin
						state_q <= ST_OUT;
						oidx_q <= 3'd0;
					end else begin
						last_blk_q <= !pad_first_q;
						state_q <= ST_PAD;
					end
				end
				ST_OUT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						state_q <= ST_LOAD;
						cv_q <= SM3_IV;
						bits_q <= 64'd0;
						fin_q <= 1'b0;
						last_blk_q <= 1'b0;
						fill_q <= 4'd0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output open together");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND && round_q == 6'd63) |=> (state_q == ST_FOLD))
		else $error("round count lost");
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_q == 4'd0 && fin_q)) else $error("digest with partial block");
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(oidx_q)) else $error("digest index moved");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams messages of varied length into the engine, with random gaps and
// output stalls, and checks each digest beat against an SM3 model kept here.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sm3_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	sm3_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	sm3_out_t out_data;

	sm3_hash_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model state.
	logic [31:0] hash_state [8];
	logic [31:0] msg_block [16];
	int unsigned block_fill;
	logic [63:0] msg_len_bits;
	sm3_out_t    digest_fifo [$];
	int          errors = 0;
	longint      cycle_count = 0;
	int          hold_cycles = 0;
	bit          stall_pattern = 1'b1;
	int          gap_left = 0;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		int k;
		k = n % 32;
		if (k == 0)
			return x;
		return (x << k) | (x >> (32 - k));
	endfunction

	function automatic void model_init();
		for (int i = 0; i < 8; i++)
			hash_state[i] = SM3_IV[255 - 32*i -: 32];
		block_fill   = 0;
		msg_len_bits = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] w [68];
		logic [31:0] a, b, c, d, e, f, g, h, t, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 16; j++)
			w[j] = msg_block[j];
		for (int j = 16; j < 68; j++) begin
			t = w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15);
			t = t ^ rotl(t, 15) ^ rotl(t, 23);
			w[j] = t ^ rotl(w[j-13], 7) ^ w[j-6];
		end
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (int j = 0; j < 64; j++) begin
			tj  = (j < 16) ? T_LOW : T_HIGH;
			a12 = rotl(a, 12);
			ss1 = rotl(a12 + e + rotl(tj, j), 7);
			ss2 = ss1 ^ a12;
			ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
			gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
			tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
			tt2 = gg + h + ss1 + w[j];
			d = c; c = rotl(b, 9); b = a; a = tt1;
			h = g; g = rotl(f, 19); f = e;
			e = tt2 ^ rotl(tt2, 9) ^ rotl(tt2, 17);
		end
		hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
		hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
	endfunction

	function automatic void load_word(input logic [31:0] word);
		msg_block[block_fill] = word;
		block_fill++;
		if (block_fill == 16) begin
			compress_block();
			block_fill = 0;
		end
	endfunction

	// Advances the model by one accepted word, queuing any digest it completes.
	function automatic void predict_digest(input sm3_in_t beat);
		int unsigned cnt;
		logic [31:0] keep, pad;
		sm3_out_t exp_beat;
		if (!beat.final_word) begin
			msg_len_bits += 64'd32;
			load_word(beat.data_word);
			return;
		end
		cnt = (beat.byte_count > 3'd4) ? 4 : beat.byte_count;
		msg_len_bits += 64'(cnt * 8);
		if (cnt == 4) begin
			load_word(beat.data_word);
			load_word({PAD_BYTE, 24'h0});
		end else begin
			keep = (cnt == 0) ? 32'h0 : (32'hffffffff << (8 * (4 - cnt)));
			pad  = 32'(PAD_BYTE) << (8 * (3 - cnt));
			load_word((beat.data_word & keep) | pad);
		end
		if (block_fill > 14)
			load_word(32'h0);
		while (block_fill < 14) begin
			msg_block[block_fill] = 32'h0;
			block_fill++;
		end
		load_word(msg_len_bits[63:32]);
		load_word(msg_len_bits[31:0]);
		for (int k = 0; k < 8; k++) begin
			exp_beat.digest_word    = hash_state[k];
			exp_beat.word_index     = 3'(k);
			exp_beat.last_of_digest = (k == 7);
			digest_fifo.push_back(exp_beat);
		end
		model_init();
	endfunction

	// Sends one word, honoring the burst gap, and updates the model on acceptance.
	// Valid stays high after the beat until the next call drops it or reloads it.
	task automatic send_word(input logic [31:0] word, input logic [2:0] cnt,
			input logic fin);
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			repeat (gap_left) @(negedge clk);
			gap_left = 0;
		end
		in_valid <= 1'b1;
		in_data  <= '{data_word: word, byte_count: cnt, final_word: fin};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_digest(in_data);
		@(negedge clk);
		if ($urandom_range(0, 5) == 0)
			gap_left = $urandom_range(1, 6);
	endtask

	task automatic send_message(input int nwords, input logic [2:0] last_cnt);
		for (int i = 0; i < nwords; i++)
			send_word($urandom(), 3'($urandom_range(0, 7)), 1'b0);
		send_word($urandom(), last_cnt, 1'b1);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (digest_fifo.size() != 0);
	endtask

	// Empty message, the standard "abc" vector and final byte counts 0 and 2 to 7.
	task automatic test_directed();
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'h616263ff, 3'd3, 1'b1);
		send_word(32'hffffffff, 3'd4, 1'b1);
		send_word(32'hffffffff, 3'd7, 1'b1);
		send_word(32'h12345678, 3'd1, 1'b0);
		send_word(32'hffffffff, 3'd2, 1'b1);
		send_word(32'h0, 3'd5, 1'b1);
		send_word(32'hdeadbeef, 3'd6, 1'b1);
	endtask

	// Lengths around the one- and two-padding-block boundaries.
	task automatic test_block_edges();
		send_message(13, 3'd4);
		send_message(14, 3'd3);
		send_message(15, 3'd1);
		send_message(15, 3'd4);
	endtask

	// Receiver holds off long enough for the input side to back up.
	task automatic test_backpressure();
		hold_cycles = 400;
		send_message(2, 3'd4);
		send_message(3, 3'd2);
		wait_drain();
	endtask

	task automatic test_random();
		int words_sent;
		int len;
		words_sent = 0;
		while (words_sent < 130) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
				: $urandom_range(0, 15);
			send_message(len, 3'($urandom_range(0, 7)));
			words_sent += len + 1;
		end
	endtask

	// Digest checker.
	always @(posedge clk) begin
		sm3_out_t want;
		if (out_valid && out_ready) begin
			if (digest_fifo.size() == 0) begin
				$display("%0t: unexpected digest beat %h", $realtime, out_data);
				errors++;
			end else begin
				want = digest_fifo.pop_front();
				if (out_data.digest_word !== want.digest_word) begin
					$display("%0t: digest_word exp %h got %h", $realtime,
						want.digest_word, out_data.digest_word);
					errors++;
				end
				if (out_data.word_index !== want.word_index) begin
					$display("%0t: word_index exp %0d got %0d", $realtime,
						want.word_index, out_data.word_index);
					errors++;
				end
				if (out_data.last_of_digest !== want.last_of_digest) begin
					$display("%0t: last_of_digest exp %0d got %0d", $realtime,
						want.last_of_digest, out_data.last_of_digest);
					errors++;
				end
			end
		end
	end

	// Receiver stall pattern, with stretches of constant readiness.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready   <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_pattern <= ~stall_pattern;
			out_ready <= stall_pattern ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		model_init();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_block_edges();
		test_backpressure();
		test_random();
		wait_drain();
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
